@@ hdl/tcw_pkg.sv @@
// tcw_pkg: shared types and constants for the text console character writer
// holds the command codes, character codes, op classes and the queued request record
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    // command codes on the input channel
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_SETCUR = 2'd3;

    // character codes with console meaning
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h00;

    // request class decided by the front end
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_NUL    = 3'd1,
        OP_LF     = 3'd2,
        OP_BS     = 3'd3,
        OP_PUT    = 3'd4,
        OP_READ   = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_SETCUR = 3'd7
    } op_t;

    // one classified request between front and back
    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
        logic       in_range;
    } item_t;

endpackage

@@ hdl/tcw_front.sv @@
// tcw_front: accepts requests and classifies them for the back end
// decodes command and character, saturates cursor targets, checks read range
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_front #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_cmd,
    input  logic [7:0]    s_char_code,
    input  logic [4:0]    s_row,
    input  logic [6:0]    s_col,
    input  logic          init_done,
    output logic          q_push,
    output tcw_pkg::item_t q_item,
    input  logic          q_ready
);
    import tcw_pkg::*;

    // take a request only once the store is initialized and the queue has room
    assign s_ready = q_ready && init_done;
    assign q_push  = s_valid && s_ready;

    // classify the request
    always_comb begin
        q_item           = '0;
        q_item.char_code = s_char_code;
        q_item.row       = s_row;
        q_item.col       = s_col;
        q_item.in_range  = (32'(s_row) < ROWS) && (32'(s_col) < COLS);
        unique case (s_cmd)
            CMD_WRITE: begin
                unique case (s_char_code)
                    CH_CR:   q_item.op = OP_NONE;
                    CH_NUL:  q_item.op = OP_NUL;
                    CH_LF:   q_item.op = OP_LF;
                    CH_BS:   q_item.op = OP_BS;
                    default: q_item.op = OP_PUT;
                endcase
            end
            CMD_READ: q_item.op = OP_READ;
            CMD_CLEAR: q_item.op = OP_CLEAR;
            CMD_SETCUR: begin
                q_item.op  = OP_SETCUR;
                // saturate the cursor target to the screen
                q_item.row = (32'(s_row) > ROWS - 1) ? 5'(ROWS - 1) : s_row;
                q_item.col = (32'(s_col) > COLS - 1) ? 7'(COLS - 1) : s_col;
            end
            default: q_item.op = OP_NONE;
        endcase
    end

endmodule

@@ hdl/tcw_queue.sv @@
// tcw_queue: two-entry queue of classified requests between front and back
// lets the front keep accepting while the back is busy
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tcw_pkg::item_t push_item,
    output logic           push_ready,
    input  logic           pop,
    output tcw_pkg::item_t pop_item,
    output logic           pop_valid
);
    import tcw_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and count update
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/tcw_back.sv @@
// tcw_back: carries out requests on the character store and cursor
// holds the screen memory with a rotating row base, the fill sweeper and the result register
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_back #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  tcw_pkg::item_t q_item,
    input  logic           q_valid,
    output logic           q_pop,
    output logic           init_done,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [4:0]     m_cursor_row,
    output logic [6:0]     m_cursor_col,
    output logic [7:0]     m_cell_char
);
    import tcw_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS + 1);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_END   = CW'(COLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(COLS);
    localparam logic [AW-1:0] ROW_SPAN  = AW'(COLS - 1);
    localparam logic [RW:0]   ROWS_W    = (RW + 1)'(ROWS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_FILL = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    // logical row to physical row through the rotating base
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
                                               input logic [RW-1:0] row);
        logic [RW:0] sum;
        sum = {1'b0, base} + {1'b0, row};
        if (sum >= ROWS_W) begin
            sum = sum - ROWS_W;
        end
        return sum[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
        return AW'(AW'(prow) * COLS_A) + AW'(col);
    endfunction

    state_t        state_reg, state_next;
    state_t        fill_ret_reg, fill_ret_next;
    item_t         item_reg, item_next;
    logic          wrap_done_reg, wrap_done_next;
    logic          init_reg, init_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] base_reg, base_next;
    logic [AW-1:0] fill_addr_reg, fill_addr_next;
    logic [AW-1:0] fill_end_reg, fill_end_next;
    logic [7:0]    fill_val_reg, fill_val_next;
    logic          m_valid_reg, m_valid_next;
    logic [4:0]    m_row_reg, m_row_next;
    logic [6:0]    m_col_reg, m_col_next;
    logic [7:0]    m_cell_reg, m_cell_next;

    logic [7:0]    screen_mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic          is_char;
    logic          do_nl;
    state_t        nl_ret;
    logic [AW-1:0] base_addr;
    logic [RW-1:0] cur_prow;

    assign is_char = (item_reg.op == OP_NUL) || (item_reg.op == OP_LF) ||
                     (item_reg.op == OP_BS) || (item_reg.op == OP_PUT);
    assign cur_prow  = phys_row(base_reg, row_reg);
    assign base_addr = cell_addr(base_reg, '0);

    assign init_done    = init_reg;
    assign m_valid      = m_valid_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cursor_col = m_col_reg;
    assign m_cell_char  = m_cell_reg;

    // request sequencer
    always_comb begin
        state_next     = state_reg;
        fill_ret_next  = fill_ret_reg;
        item_next      = item_reg;
        wrap_done_next = wrap_done_reg;
        init_next      = init_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        fill_val_next  = fill_val_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        m_cell_next    = m_cell_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = fill_addr_reg;
        mem_wdata      = fill_val_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        do_nl          = 1'b0;
        nl_ret         = S_RESP;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop          = 1'b1;
                    item_next      = q_item;
                    wrap_done_next = 1'b0;
                    state_next     = S_EXEC;
                end
            end

            S_EXEC: begin
                if (is_char && (col_reg >= COL_END) && !wrap_done_reg) begin
                    // resolve a pending wrap before the character itself
                    do_nl          = 1'b1;
                    nl_ret         = S_EXEC;
                    wrap_done_next = 1'b1;
                end else begin
                    state_next = S_RESP;
                    case (item_reg.op)
                        OP_LF: do_nl = 1'b1;
                        OP_BS: begin
                            if (col_reg != '0) begin
                                col_next  = col_reg - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(cur_prow, col_reg - 1'b1);
                                mem_wdata = CH_SPACE;
                            end
                        end
                        OP_PUT: begin
                            col_next  = col_reg + 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(cur_prow, col_reg);
                            mem_wdata = item_reg.char_code;
                        end
                        OP_READ: begin
                            mem_re    = item_reg.in_range;
                            mem_raddr = cell_addr(phys_row(base_reg, RW'(item_reg.row)),
                                                  CW'(item_reg.col));
                        end
                        OP_CLEAR: begin
                            row_next       = '0;
                            col_next       = '0;
                            base_next      = '0;
                            fill_addr_next = '0;
                            fill_end_next  = LAST_ADDR;
                            fill_val_next  = CH_SPACE;
                            fill_ret_next  = S_RESP;
                            state_next     = S_FILL;
                        end
                        OP_SETCUR: begin
                            row_next = RW'(item_reg.row);
                            col_next = CW'(item_reg.col);
                        end
                        default: begin
                        end
                    endcase
                end

                // step to the next line, scrolling on the last row
                if (do_nl) begin
                    col_next = '0;
                    if (row_reg >= LAST_ROW) begin
                        row_next       = LAST_ROW;
                        base_next      = phys_row(base_reg, RW'(1));
                        fill_addr_next = base_addr;
                        fill_end_next  = base_addr + ROW_SPAN;
                        fill_val_next  = CH_ZERO;
                        fill_ret_next  = nl_ret;
                        state_next     = S_FILL;
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = nl_ret;
                    end
                end
            end

            S_FILL: begin
                // one cell per cycle over the fill range
                mem_we = 1'b1;
                if (fill_addr_reg == fill_end_reg) begin
                    state_next = fill_ret_reg;
                    init_next  = 1'b1;
                end else begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end

            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_row_next   = 5'(row_reg);
                    m_col_next   = 7'(col_reg);
                    m_cell_next  = (item_reg.op == OP_READ && item_reg.in_range) ?
                                   rd_data_reg : CH_ZERO;
                    if (q_valid) begin
                        q_pop          = 1'b1;
                        item_next      = q_item;
                        wrap_done_next = 1'b0;
                        state_next     = S_EXEC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FILL;
            fill_ret_reg  <= S_IDLE;
            wrap_done_reg <= 1'b0;
            init_reg      <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            fill_addr_reg <= '0;
            fill_end_reg  <= LAST_ADDR;
            fill_val_reg  <= CH_SPACE;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_ret_reg  <= fill_ret_next;
            wrap_done_reg <= wrap_done_next;
            init_reg      <= init_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            fill_val_reg  <= fill_val_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        m_row_reg  <= m_row_next;
        m_col_reg  <= m_col_next;
        m_cell_reg <= m_cell_next;
    end

    // character store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

endmodule

@@ hdl/text_console_char_writer.sv @@
// text_console_char_writer: ROWS x COLS text console store with one cursor
// each request goes through an execute step, then a respond step, on the single store
// a pending wrap adds a newline step before the character; each scroll clears the new
// bottom row to zero through the fill sweeper (a newline after a wrap on the bottom row
// scrolls twice); clear screen fills every cell with spaces; after reset the same pass
// fills the store while s_ready stays low
`timescale 1ns / 1ps

module text_console_char_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_char_code,
    input  logic [4:0] s_row,
    input  logic [6:0] s_col,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_cursor_row,
    output logic [6:0] m_cursor_col,
    output logic [7:0] m_cell_char
);
    import tcw_pkg::*;

    item_t front_item;
    item_t back_item;
    logic  q_push, q_ready, q_pop, q_valid;
    logic  init_done;

    // front end: accept and classify
    tcw_front #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_char_code (s_char_code),
        .s_row       (s_row),
        .s_col       (s_col),
        .init_done   (init_done),
        .q_push      (q_push),
        .q_item      (front_item),
        .q_ready     (q_ready)
    );

    // request queue
    tcw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (front_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_item   (back_item),
        .pop_valid  (q_valid)
    );

    // back end: store, cursor and result
    tcw_back #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_item       (back_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .init_done    (init_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_cell_char  (m_cell_char)
    );

    // reported cursor row always lies on the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_cursor_row) < ROWS))
        else $error("cursor row beyond last row");

    // no request is taken while the store is still being initialized
    assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_ready)
        else $error("request accepted during clearing pass");

    // the back end only pops a request the queue actually holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty request queue");

endmodule

@@ sim/tb.sv @@
// tb: self-checking bench for text_console_char_writer (directed table, then random sessions)
// keeps a shadow screen and cursor, predicts every response and compares it field by field
// depends on hdl/tcw_pkg.sv and hdl/text_console_char_writer.sv
`timescale 1ns / 1ps

module tb;
    import tcw_pkg::*;

    localparam int NUM_COLS    = 80;
    localparam int NUM_ROWS    = 25;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_ITEMS = 150;
    localparam int MAX_PRINTED = 40;

    // one response as it appears on the m_ channel
    typedef struct packed {
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] char_val;
    } status_t;

    // side note per request: a hand-typed response overrides the prediction
    typedef struct packed {
        logic    typed;
        status_t want;
    } note_t;

    // one row of the directed table
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
        note_t      note;
    } step_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_cmd = CMD_WRITE;
    logic [7:0] s_char_code = CH_NUL;
    logic [4:0] s_row = '0;
    logic [6:0] s_col = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [4:0] m_cursor_row;
    logic [6:0] m_cursor_col;
    logic [7:0] m_cell_char;

    // shadow copy of the console
    logic [7:0] shadow_screen [NUM_ROWS*NUM_COLS];
    int         shadow_row;
    int         shadow_col;

    status_t    expected_status_q[$];
    note_t      request_notes_q[$];
    step_t      directed_steps[$];

    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    bit         hold_wanted = 1'b0;
    int         mismatch_count = 0;
    int         sent_count = 0;

    text_console_char_writer #(
        .COLS(NUM_COLS),
        .ROWS(NUM_ROWS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_char_code (s_char_code),
        .s_row       (s_row),
        .s_col       (s_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cursor_row(m_cursor_row),
        .m_cursor_col(m_cursor_col),
        .m_cell_char (m_cell_char)
    );

    always #5 aclk = ~aclk;

    // step to the next line, scrolling when already on the bottom row
    function automatic void line_feed();
        if (shadow_row >= NUM_ROWS - 1) begin
            shadow_row = NUM_ROWS - 1;
            for (int i = 0; i < (NUM_ROWS - 1) * NUM_COLS; i++)
                shadow_screen[i] = shadow_screen[i + NUM_COLS];
            for (int i = (NUM_ROWS - 1) * NUM_COLS; i < NUM_ROWS * NUM_COLS; i++)
                shadow_screen[i] = CH_ZERO;
            shadow_col = 0;
        end else begin
            shadow_row = shadow_row + 1;
            shadow_col = 0;
        end
    endfunction

    // apply one request to the shadow console and return the response it gives
    function automatic status_t console_response(input logic [1:0] cmd, input logic [7:0] ch,
                                                 input logic [4:0] r, input logic [6:0] c);
        status_t st;
        logic [7:0] cell_val;
        cell_val = CH_ZERO;
        case (cmd)
            CMD_WRITE: begin
                // carriage return leaves even a pending wrap alone
                if (ch != CH_CR) begin
                    if (shadow_col >= NUM_COLS)
                        line_feed();
                    if (ch == CH_LF) begin
                        line_feed();
                    end else if (ch == CH_BS) begin
                        if (shadow_col != 0) begin
                            shadow_col = shadow_col - 1;
                            shadow_screen[shadow_row * NUM_COLS + shadow_col] = CH_SPACE;
                        end
                    end else if (ch != CH_NUL) begin
                        shadow_screen[shadow_row * NUM_COLS + shadow_col] = ch;
                        shadow_col = shadow_col + 1;
                    end
                end
            end
            CMD_READ: begin
                if (r < NUM_ROWS && c < NUM_COLS)
                    cell_val = shadow_screen[r * NUM_COLS + c];
            end
            CMD_CLEAR: begin
                foreach (shadow_screen[i])
                    shadow_screen[i] = CH_SPACE;
                shadow_row = 0;
                shadow_col = 0;
            end
            default: begin
                shadow_row = (r > NUM_ROWS - 1) ? NUM_ROWS - 1 : int'(r);
                shadow_col = (c > NUM_COLS - 1) ? NUM_COLS - 1 : int'(c);
            end
        endcase
        st.row      = 5'(shadow_row);
        st.col      = 7'(shadow_col);
        st.char_val = cell_val;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // request side: predict on acceptance; response side: check against the oldest expectation
    always @(posedge aclk) begin
        status_t got;
        status_t want;
        note_t   note;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                note = request_notes_q.pop_front();
                want = console_response(s_cmd, s_char_code, s_row, s_col);
                expected_status_q.push_back(note.typed ? note.want : want);
            end
            if (m_valid && m_ready) begin
                got = '{row: m_cursor_row, col: m_cursor_col, char_val: m_cell_char};
                if (expected_status_q.size() == 0) begin
                    report_mismatch("response with no request pending", 1, 0);
                end else begin
                    want = expected_status_q.pop_front();
                    if (got.row !== want.row)
                        report_mismatch("cursor_row", got.row, want.row);
                    if (got.col !== want.col)
                        report_mismatch("cursor_col", got.col, want.col);
                    if (got.char_val !== want.char_val)
                        report_mismatch("cell_char", got.char_val, want.char_val);
                end
            end
        end
    end

    // response side ready: random stalls, plus one long hold-off on demand
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_req(input logic [1:0] cmd, input logic [7:0] ch, input logic [4:0] r,
                            input logic [6:0] c, input note_t note);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        request_notes_q.push_back(note);
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_char_code <= ch;
        s_row       <= r;
        s_col       <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // carriage return and nul write no character, so they do not count
        if (!(cmd == CMD_WRITE && (ch == CH_CR || ch == CH_NUL)))
            sent_count++;
    endtask

    // sender pauses until every expected response is back
    task automatic drain_responses();
        s_valid <= 1'b0;
        do @(posedge aclk);
        while (request_notes_q.size() != 0 || expected_status_q.size() != 0);
    endtask

    task automatic add_step(input logic [1:0] cmd, input logic [7:0] ch, input logic [4:0] r,
                            input logic [6:0] c, input logic typed, input logic [4:0] er,
                            input logic [6:0] ec, input logic [7:0] ecell);
        step_t s;
        s.cmd  = cmd;
        s.ch   = ch;
        s.row  = r;
        s.col  = c;
        s.note = '{typed: typed, want: '{row: er, col: ec, char_val: ecell}};
        directed_steps.push_back(s);
    endtask

    // a burst of typed text: mostly printable, some control characters and raw bytes
    task automatic type_text(input int len);
        logic [7:0] ch;
        int k;
        for (int n = 0; n < len; n++) begin
            k = $urandom_range(99);
            if (k < 6)
                ch = CH_LF;
            else if (k < 10)
                ch = CH_BS;
            else if (k < 13)
                ch = CH_CR;
            else if (k < 15)
                ch = CH_NUL;
            else if (k < 22)
                ch = 8'($urandom_range(255));
            else
                ch = 8'($urandom_range(8'h7e, 8'h21));
            send_req(CMD_WRITE, ch, 5'($urandom_range(31)), 7'($urandom_range(127)), '0);
        end
    endtask

    // random sessions until enough counted requests have gone out
    task automatic random_session(input int n_items);
        int start;
        int pick;
        start = sent_count;
        while (sent_count - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                type_text($urandom_range(40, 3));
            end else if (pick < 55) begin
                // park near the line end, often on the bottom row, to hit wrap and scroll
                send_req(CMD_SETCUR, 8'($urandom_range(255)),
                         ($urandom_range(1) != 0) ? 5'(NUM_ROWS - 1) : 5'($urandom_range(24)),
                         7'($urandom_range(79, 70)), '0);
                type_text($urandom_range(20, 5));
            end else if (pick < 80) begin
                repeat ($urandom_range(4, 1)) begin
                    if ($urandom_range(99) < 15)
                        send_req(CMD_READ, 8'($urandom_range(255)), 5'($urandom_range(31)),
                                 7'($urandom_range(127)), '0);
                    else if ($urandom_range(1) != 0)
                        send_req(CMD_READ, 8'($urandom_range(255)), 5'(shadow_row),
                                 7'($urandom_range(79)), '0);
                    else
                        send_req(CMD_READ, 8'($urandom_range(255)), 5'($urandom_range(24)),
                                 7'($urandom_range(79)), '0);
                end
            end else if (pick < 95) begin
                send_req(CMD_SETCUR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                         7'($urandom_range(127)), '0);
            end else if (pick < 97) begin
                send_req(CMD_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                         7'($urandom_range(127)), '0);
            end else begin
                // noise: any command with any field values
                send_req(2'($urandom_range(3)), 8'($urandom_range(255)),
                         5'($urandom_range(31)), 7'($urandom_range(127)), '0);
            end
        end
    endtask

    // stimulus
    initial begin
        foreach (shadow_screen[i])
            shadow_screen[i] = CH_SPACE;
        shadow_row = 0;
        shadow_col = 0;

        // directed table; typed responses where they are obvious
        add_step(CMD_READ,   CH_NUL,   5'd0,  7'd0,   1'b1, 5'd0,  7'd0,  CH_SPACE);
        add_step(CMD_SETCUR, CH_NUL,   5'd31, 7'd127, 1'b1, 5'd24, 7'd79, CH_ZERO);
        add_step(CMD_READ,   CH_NUL,   5'd31, 7'd127, 1'b1, 5'd24, 7'd79, CH_ZERO);
        add_step(CMD_READ,   CH_NUL,   5'd24, 7'd80,  1'b1, 5'd24, 7'd79, CH_ZERO);
        add_step(CMD_WRITE,  8'h41,    5'd0,  7'd0,   1'b1, 5'd24, 7'd80, CH_ZERO);
        add_step(CMD_WRITE,  CH_CR,    5'd0,  7'd0,   1'b1, 5'd24, 7'd80, CH_ZERO);
        // wrap on the bottom row scrolls before the character lands
        add_step(CMD_WRITE,  8'h42,    5'd0,  7'd0,   1'b0, '0, '0, '0);
        add_step(CMD_READ,   CH_NUL,   5'd23, 7'd79,  1'b0, '0, '0, '0);
        add_step(CMD_READ,   CH_NUL,   5'd24, 7'd1,   1'b0, '0, '0, '0);
        add_step(CMD_WRITE,  CH_BS,    5'd0,  7'd0,   1'b0, '0, '0, '0);
        // backspace at column zero does nothing
        add_step(CMD_WRITE,  CH_BS,    5'd0,  7'd0,   1'b0, '0, '0, '0);
        add_step(CMD_WRITE,  CH_NUL,   5'd0,  7'd0,   1'b0, '0, '0, '0);
        add_step(CMD_WRITE,  CH_LF,    5'd0,  7'd0,   1'b0, '0, '0, '0);
        add_step(CMD_SETCUR, 8'hff,    5'd0,  7'd0,   1'b1, 5'd0,  7'd0,  CH_ZERO);
        add_step(CMD_WRITE,  CH_LF,    5'd31, 7'd127, 1'b1, 5'd1,  7'd0,  CH_ZERO);
        add_step(CMD_WRITE,  8'hff,    5'd0,  7'd0,   1'b1, 5'd1,  7'd1,  CH_ZERO);
        add_step(CMD_READ,   CH_NUL,   5'd1,  7'd0,   1'b1, 5'd1,  7'd1,  8'hff);
        // pending wrap above the bottom row, resolved by a nul
        add_step(CMD_SETCUR, CH_NUL,   5'd3,  7'd79,  1'b1, 5'd3,  7'd79, CH_ZERO);
        add_step(CMD_WRITE,  8'h7f,    5'd0,  7'd0,   1'b1, 5'd3,  7'd80, CH_ZERO);
        add_step(CMD_WRITE,  CH_NUL,   5'd0,  7'd0,   1'b1, 5'd4,  7'd0,  CH_ZERO);
        // newline after a wrap on the bottom row scrolls twice
        add_step(CMD_SETCUR, CH_NUL,   5'd24, 7'd79,  1'b1, 5'd24, 7'd79, CH_ZERO);
        add_step(CMD_WRITE,  8'h79,    5'd0,  7'd0,   1'b1, 5'd24, 7'd80, CH_ZERO);
        add_step(CMD_WRITE,  CH_LF,    5'd0,  7'd0,   1'b0, '0, '0, '0);
        add_step(CMD_CLEAR,  8'hff,    5'd31, 7'd127, 1'b1, 5'd0,  7'd0,  CH_ZERO);
        add_step(CMD_READ,   CH_NUL,   5'd24, 7'd79,  1'b1, 5'd0,  7'd0,  CH_SPACE);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i])
            send_req(directed_steps[i].cmd, directed_steps[i].ch, directed_steps[i].row,
                     directed_steps[i].col, directed_steps[i].note);
        drain_responses();

        // random sessions under each idling pattern
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  hold_wanted = 1'b1; end
                1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
                default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            random_session(PHASE_ITEMS);
            drain_responses();
        end

        rx_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #100ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
